FILE: sv/kqs_pkg.sv
// ----------------------------------------------------------------------------
// kqs_pkg
// Shared constants and record type for the keyed quicksort engine.
// ----------------------------------------------------------------------------
package kqs_pkg;

    localparam int DEPTH     = 64;
    localparam int KEY_BITS  = 32;
    localparam int NODE_BITS = 16;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int REC_W  = KEY_BITS + 2 * NODE_BITS;
    localparam int STK_W  = 2 * ADDR_W;

    typedef struct packed {
        logic [KEY_BITS-1:0]  key;
        logic [NODE_BITS-1:0] tgt;
        logic [NODE_BITS-1:0] src;
    } t_rec;

endpackage

FILE: sv/kqs_rec_ram.sv
// ----------------------------------------------------------------------------
// kqs_rec_ram
// Record store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module kqs_rec_ram #(
    parameter int WIDTH  = 64,
    parameter int WORDS  = 64,
    parameter int AWIDTH = $clog2(WORDS)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AWIDTH-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_ra_en,
    input  logic [AWIDTH-1:0] i_ra_addr,
    output logic [WIDTH-1:0]  o_ra_data,
    input  logic              i_rb_en,
    input  logic [AWIDTH-1:0] i_rb_addr,
    output logic [WIDTH-1:0]  o_rb_data
);

    logic [WIDTH-1:0] r_mem [WORDS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ra_en) begin
            o_ra_data <= r_mem[i_ra_addr];
        end
        if (i_rb_en) begin
            o_rb_data <= r_mem[i_rb_addr];
        end
    end

endmodule

FILE: sv/keyed_quicksort_engine_core.sv
// ----------------------------------------------------------------------------
// keyed_quicksort_engine_core
// Loads edge records, sorts them by key with an in-place Lomuto quicksort
// driven by a range stack, then emits the sorted run.
// ----------------------------------------------------------------------------
// Loading: one beat per cycle, one record per beat.
// Sorting: per range, pop it from the stack and read the pivot, then read and
// compare each element left of the pivot (a swap adds a write step), then place
// the pivot and push subranges; the record store has a single write port.
// Emission: per record, a store read, then an output beat.
// Reset is synchronous; it clears count, flag, stack pointer and sequencer, not the stores.
module keyed_quicksort_engine_core
    import kqs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [KEY_BITS-1:0]  i_weight_key,
    input  logic [NODE_BITS-1:0] i_source_node,
    input  logic [NODE_BITS-1:0] i_target_node,
    input  logic                 i_is_last,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [KEY_BITS-1:0]  o_sorted_key,
    output logic [NODE_BITS-1:0] o_sorted_source,
    output logic [NODE_BITS-1:0] o_sorted_target,
    output logic                 o_final_record,
    output logic                 o_overflowed
);

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_POP   = 4'd1;
    localparam logic [3:0] S_POPW  = 4'd2;
    localparam logic [3:0] S_PIV   = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_CMP   = 4'd5;
    localparam logic [3:0] S_SW2   = 4'd6;
    localparam logic [3:0] S_FSW   = 4'd7;
    localparam logic [3:0] S_FSW2  = 4'd8;
    localparam logic [3:0] S_PUSHL = 4'd9;
    localparam logic [3:0] S_EMIT  = 4'd10;
    localparam logic [3:0] S_EOUT  = 4'd11;

    logic [3:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_ovf, n_ovf;
    logic [CNT_W-1:0]    r_top, n_top;
    logic [ADDR_W-1:0]   r_lo, n_lo;
    logic [ADDR_W-1:0]   r_hi, n_hi;
    logic [ADDR_W-1:0]   r_i, n_i;
    logic [ADDR_W-1:0]   r_place, n_place;
    logic [ADDR_W-1:0]   r_idx, n_idx;
    logic [KEY_BITS-1:0] r_pivot, n_pivot;
    t_rec                r_hold, n_hold;

    logic [STK_W-1:0]  r_stack [DEPTH];
    logic [STK_W-1:0]  r_stk_rd;
    logic              stk_we, stk_re;
    logic [ADDR_W-1:0] stk_waddr, stk_raddr;
    logic [STK_W-1:0]  stk_wdata;

    logic              ram_we, ram_ra_en, ram_rb_en;
    logic [ADDR_W-1:0] ram_waddr, ram_ra_addr, ram_rb_addr;
    t_rec              ram_wdata, rda, rdb;

    logic              full, accept;
    logic [CNT_W-1:0]  cnt_acc, top_m1, idx_ext, place_ext, lo_ext, hi_ext;
    logic [ADDR_W-1:0] stk_lo, stk_hi;

    kqs_rec_ram #(
        .WIDTH (REC_W),
        .WORDS (DEPTH)
    ) u_rec_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_ra_en   (ram_ra_en),
        .i_ra_addr (ram_ra_addr),
        .o_ra_data (rda),
        .i_rb_en   (ram_rb_en),
        .i_rb_addr (ram_rb_addr),
        .o_rb_data (rdb)
    );

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            r_stk_rd <= r_stack[stk_raddr];
        end
    end

    assign full      = (r_count == CNT_W'(DEPTH));
    assign accept    = i_valid && (r_state == S_LOAD);
    assign cnt_acc   = full ? r_count : r_count + CNT_W'(1);
    assign top_m1    = r_top - CNT_W'(1);
    assign idx_ext   = CNT_W'(r_idx);
    assign place_ext = CNT_W'(r_place);
    assign lo_ext    = CNT_W'(r_lo);
    assign hi_ext    = CNT_W'(r_hi);
    assign stk_lo    = r_stk_rd[STK_W-1:ADDR_W];
    assign stk_hi    = r_stk_rd[ADDR_W-1:0];

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_top     = r_top;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_i       = r_i;
        n_place   = r_place;
        n_idx     = r_idx;
        n_pivot   = r_pivot;
        n_hold    = r_hold;
        stk_we    = 1'b0;
        stk_waddr = r_top[ADDR_W-1:0];
        stk_wdata = '0;
        stk_re    = 1'b0;
        stk_raddr = top_m1[ADDR_W-1:0];
        ram_we    = 1'b0;
        ram_waddr = r_i;
        ram_wdata = rdb;
        ram_ra_en   = 1'b0;
        ram_ra_addr = r_i;
        ram_rb_en   = 1'b0;
        ram_rb_addr = r_place;

        case (r_state)
            S_LOAD: begin
                if (accept) begin
                    ram_we        = !full;
                    ram_waddr     = r_count[ADDR_W-1:0];
                    ram_wdata.key = i_weight_key;
                    ram_wdata.src = i_source_node;
                    ram_wdata.tgt = i_target_node;
                    n_count       = cnt_acc;
                    n_ovf         = r_ovf | full;
                    n_idx         = '0;
                    if (i_is_last) begin
                        if (cnt_acc < CNT_W'(2)) begin
                            n_state = S_EMIT;
                        end else begin
                            stk_we    = 1'b1;
                            stk_waddr = '0;
                            stk_wdata = {ADDR_W'(0), cnt_acc[ADDR_W-1:0] - ADDR_W'(1)};
                            n_top     = CNT_W'(1);
                            n_state   = S_POP;
                        end
                    end
                end
            end
            S_POP: begin
                if (r_top == '0) begin
                    n_idx   = '0;
                    n_state = S_EMIT;
                end else begin
                    stk_re  = 1'b1;
                    n_top   = top_m1;
                    n_state = S_POPW;
                end
            end
            S_POPW: begin
                n_lo = stk_lo;
                n_hi = stk_hi;
                if (stk_lo >= stk_hi) begin
                    n_state = S_POP;
                end else begin
                    ram_ra_en   = 1'b1;
                    ram_ra_addr = stk_hi;
                    n_state     = S_PIV;
                end
            end
            S_PIV: begin
                n_pivot = rda.key;
                n_i     = r_lo;
                n_place = r_lo;
                n_state = S_RD;
            end
            S_RD: begin
                ram_ra_en = 1'b1;
                ram_rb_en = 1'b1;
                if (r_i == r_hi) begin
                    ram_ra_addr = r_hi;
                    n_state     = S_FSW;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (rda.key <= r_pivot) begin
                    ram_we  = 1'b1;
                    n_hold  = rda;
                    n_state = S_SW2;
                end else begin
                    n_i     = r_i + ADDR_W'(1);
                    n_state = S_RD;
                end
            end
            S_SW2: begin
                ram_we    = 1'b1;
                ram_waddr = r_place;
                ram_wdata = r_hold;
                n_place   = r_place + ADDR_W'(1);
                n_i       = r_i + ADDR_W'(1);
                n_state   = S_RD;
            end
            S_FSW: begin
                ram_we    = 1'b1;
                ram_waddr = r_hi;
                n_hold    = rda;
                n_state   = S_FSW2;
            end
            S_FSW2: begin
                ram_we    = 1'b1;
                ram_waddr = r_place;
                ram_wdata = r_hold;
                if (place_ext + CNT_W'(1) < hi_ext) begin
                    stk_we    = 1'b1;
                    stk_wdata = {r_place + ADDR_W'(1), r_hi};
                    n_top     = r_top + CNT_W'(1);
                end
                n_state = S_PUSHL;
            end
            S_PUSHL: begin
                if (place_ext > lo_ext + CNT_W'(1)) begin
                    stk_we    = 1'b1;
                    stk_wdata = {r_lo, r_place - ADDR_W'(1)};
                    n_top     = r_top + CNT_W'(1);
                end
                n_state = S_POP;
            end
            S_EMIT: begin
                ram_ra_en   = 1'b1;
                ram_ra_addr = r_idx;
                n_state     = S_EOUT;
            end
            S_EOUT: begin
                if (!i_stall) begin
                    if (idx_ext == r_count - CNT_W'(1)) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_idx   = r_idx + ADDR_W'(1);
                        n_state = S_EMIT;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_top   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_top   <= n_top;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_i     <= n_i;
        r_place <= n_place;
        r_idx   <= n_idx;
        r_pivot <= n_pivot;
        r_hold  <= n_hold;
    end

    assign o_stall         = (r_state != S_LOAD);
    assign o_valid         = (r_state == S_EOUT);
    assign o_sorted_key    = rda.key;
    assign o_sorted_source = rda.src;
    assign o_sorted_target = rda.tgt;
    assign o_final_record  = (idx_ext == r_count - CNT_W'(1));
    assign o_overflowed    = r_ovf;

endmodule

FILE: sv/kqs_checker.sv
// ----------------------------------------------------------------------------
// kqs_checker
// Port-level checks on the keyed quicksort engine, bound to the top level.
// ----------------------------------------------------------------------------
module kqs_checker
    import kqs_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic [KEY_BITS-1:0]  o_sorted_key,
    input logic                 o_final_record,
    input logic                 o_overflowed
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sorted_key))
        else $error("output beat changed while stalled");

    // no loading while a sorted run is out
    a_busy_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open during emission");

    // run ends on its final beat
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_final_record |=> !o_valid && !o_stall)
        else $error("emission continued past final beat");

    // overflow flag constant across one run
    a_ovf_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_final_record |=> ##1
            (o_valid && (o_overflowed == $past(o_overflowed, 2))))
        else $error("overflow flag changed within a run");

endmodule

bind keyed_quicksort_engine_core kqs_checker u_kqs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_sorted_key   (o_sorted_key),
    .o_final_record (o_final_record),
    .o_overflowed   (o_overflowed)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for keyed_quicksort_engine_core. Edge records are sent in sets
// ended by a last mark. A behavioural Lomuto quicksort with a range stack
// predicts each sorted run. Every output beat is checked against the oldest
// prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import kqs_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int ITEM_TARGET = 140;
    localparam int IDLE_PCT    = 18;
    localparam int TAIL_CYCLES = 400;
    localparam int TIMEOUT_NS  = 15_000_000;
    localparam int SORT_SLOTS  = 2 * DEPTH;
    localparam int RANGE_SLOTS = DEPTH + 2;

    typedef struct {
        logic [KEY_BITS-1:0]  key;
        logic [NODE_BITS-1:0] src;
        logic [NODE_BITS-1:0] tgt;
        logic                 fin;
        logic                 ovf;
    } t_sorted_beat;

    typedef enum int {
        KEYS_RANDOM,
        KEYS_CLUSTERED,
        KEYS_RISING,
        KEYS_FALLING
    } t_key_style;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_valid         = 1'b0;
    logic                 i_stall         = 1'b0;
    logic [KEY_BITS-1:0]  i_weight_key    = '0;
    logic [NODE_BITS-1:0] i_source_node   = '0;
    logic [NODE_BITS-1:0] i_target_node   = '0;
    logic                 i_is_last       = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [KEY_BITS-1:0]  o_sorted_key;
    logic [NODE_BITS-1:0] o_sorted_source;
    logic [NODE_BITS-1:0] o_sorted_target;
    logic                 o_final_record;
    logic                 o_overflowed;

    t_rec         edge_store [DEPTH];
    int unsigned  edge_count   = 0;
    bit           edge_dropped = 1'b0;
    t_sorted_beat sorted_buf [SORT_SLOTS];
    int unsigned  sorted_wr    = 0;
    int unsigned  sorted_rd    = 0;
    int unsigned  items_sent   = 0;
    int unsigned  err_count    = 0;
    bit           calm         = 1'b0;

    keyed_quicksort_engine_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_weight_key    (i_weight_key),
        .i_source_node   (i_source_node),
        .i_target_node   (i_target_node),
        .i_is_last       (i_is_last),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_sorted_key    (o_sorted_key),
        .o_sorted_source (o_sorted_source),
        .o_sorted_target (o_sorted_target),
        .o_final_record  (o_final_record),
        .o_overflowed    (o_overflowed)
    );

    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_stall = !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // ---- sort prediction ----

    function automatic void swap_edges(int unsigned a, int unsigned b);
        t_rec tmp;
        tmp           = edge_store[a];
        edge_store[a] = edge_store[b];
        edge_store[b] = tmp;
    endfunction

    function automatic int unsigned lomuto_split(int unsigned lo, int unsigned hi);
        logic [KEY_BITS-1:0] pivot;
        int unsigned         place;
        pivot = edge_store[hi].key;
        place = lo;
        for (int unsigned i = lo; i < hi; i++) begin
            if (edge_store[i].key <= pivot) begin
                swap_edges(i, place);
                place++;
            end
        end
        swap_edges(hi, place);
        return place;
    endfunction

    function automatic void sort_edges(int unsigned n);
        int unsigned lo_stk [RANGE_SLOTS];
        int unsigned hi_stk [RANGE_SLOTS];
        int unsigned top;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        if (n < 2)
            return;
        lo_stk[0] = 0;
        hi_stk[0] = n - 1;
        top       = 1;
        while (top > 0) begin
            top--;
            lo = lo_stk[top];
            hi = hi_stk[top];
            if (lo >= hi)
                continue;
            mid = lomuto_split(lo, hi);
            // right range first so the left one is taken next
            if (mid + 1 < hi && top < RANGE_SLOTS) begin
                lo_stk[top] = mid + 1;
                hi_stk[top] = hi;
                top++;
            end
            if (mid > lo + 1 && top < RANGE_SLOTS) begin
                lo_stk[top] = lo;
                hi_stk[top] = mid - 1;
                top++;
            end
        end
    endfunction

    function automatic void predict_edge(t_rec r, logic last);
        t_sorted_beat beat;
        if (edge_count < DEPTH) begin
            edge_store[edge_count] = r;
            edge_count++;
        end else begin
            edge_dropped = 1'b1;
        end
        if (last) begin
            sort_edges(edge_count);
            for (int unsigned k = 0; k < edge_count; k++) begin
                beat.key = edge_store[k].key;
                beat.src = edge_store[k].src;
                beat.tgt = edge_store[k].tgt;
                beat.fin = (k + 1 == edge_count);
                beat.ovf = edge_dropped;
                sorted_buf[sorted_wr % SORT_SLOTS] = beat;
                sorted_wr++;
            end
            edge_count   = 0;
            edge_dropped = 1'b0;
        end
    endfunction

    // ---- output checking ----

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge i_clk) begin : sorted_check
        t_sorted_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (sorted_wr == sorted_rd) begin
                $error("unexpected beat: key %h src %h tgt %h",
                       o_sorted_key, o_sorted_source, o_sorted_target);
                err_count++;
            end else begin
                want = sorted_buf[sorted_rd % SORT_SLOTS];
                sorted_rd++;
                check_field("sorted_key",    64'(want.key), 64'(o_sorted_key));
                check_field("sorted_source", 64'(want.src), 64'(o_sorted_source));
                check_field("sorted_target", 64'(want.tgt), 64'(o_sorted_target));
                check_field("final_record",  64'(want.fin), 64'(o_final_record));
                check_field("overflowed",    64'(want.ovf), 64'(o_overflowed));
            end
        end
    end

    // ---- stimulus ----

    task automatic send_edge(logic [KEY_BITS-1:0] key, logic [NODE_BITS-1:0] src,
                             logic [NODE_BITS-1:0] tgt, logic last);
        t_rec r;
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid       = 1'b0;
            i_weight_key  = $urandom();
            i_source_node = NODE_BITS'($urandom());
            i_target_node = NODE_BITS'($urandom());
            i_is_last     = 1'($urandom_range(1));
            @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_weight_key  = key;
        i_source_node = src;
        i_target_node = tgt;
        i_is_last     = last;
        do @(posedge i_clk); while (o_stall);
        r.key = key;
        r.src = src;
        r.tgt = tgt;
        predict_edge(r, last);
        items_sent++;
    endtask

    task automatic wait_sorted_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sorted_wr != sorted_rd)
            @(posedge i_clk);
    endtask

    task automatic send_set(int unsigned n, t_key_style style);
        logic [KEY_BITS-1:0] key;
        for (int unsigned i = 0; i < n; i++) begin
            case (style)
                KEYS_CLUSTERED: key = $urandom_range(7);
                KEYS_RISING:    key = (i << 20) | $urandom_range(32'h000F_FFFF);
                KEYS_FALLING:   key = ~((i << 20) | $urandom_range(32'h000F_FFFF));
                default:        key = $urandom();
            endcase
            send_edge(key, NODE_BITS'($urandom()), NODE_BITS'($urandom()), i == n - 1);
        end
    endtask

    // ---- tests ----

    task automatic test_single_record();
        send_edge(32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 1'b1);
        send_edge(32'h0000_0000, 16'h0000, 16'hFFFF, 1'b1);
        wait_sorted_drained();
    endtask

    task automatic test_field_extremes();
        send_edge(32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 1'b0);
        send_edge(32'h0000_0000, 16'h0000, 16'hFFFF, 1'b0);
        send_edge(32'h8000_0000, 16'hAAAA, 16'h5555, 1'b0);
        send_edge(32'h0001_0000, 16'h5555, 16'hAAAA, 1'b0);
        send_edge(32'h0000_FFFF, 16'h1234, 16'hFEDC, 1'b1);
        wait_sorted_drained();
    endtask

    // equal keys: payload order must follow the partition scheme
    task automatic test_equal_keys();
        send_edge(32'd7, 16'h0001, 16'h0101, 1'b0);
        send_edge(32'd3, 16'h0002, 16'h0202, 1'b0);
        send_edge(32'd7, 16'h0003, 16'h0303, 1'b0);
        send_edge(32'd7, 16'h0004, 16'h0404, 1'b0);
        send_edge(32'd3, 16'h0005, 16'h0505, 1'b1);
        wait_sorted_drained();
    endtask

    task automatic test_presorted_runs();
        send_set(6, KEYS_RISING);
        send_set(6, KEYS_FALLING);
        wait_sorted_drained();
    endtask

    task automatic test_full_store();
        send_set(DEPTH, KEYS_FALLING);
        wait_sorted_drained();
    endtask

    // last beat dropped on a full store, then a longer overrun,
    // then a short set to see the flag cleared
    task automatic test_overflow();
        send_set(DEPTH + 1, KEYS_RANDOM);
        send_set(DEPTH + 6, KEYS_CLUSTERED);
        send_set(3, KEYS_RANDOM);
        wait_sorted_drained();
    endtask

    task automatic test_no_idle();
        @(negedge i_clk);
        calm = 1'b1;
        send_set(20, KEYS_RANDOM);
        send_set(10, KEYS_CLUSTERED);
        send_set(1, KEYS_RANDOM);
        wait_sorted_drained();
        calm = 1'b0;
    endtask

    task automatic test_random_sets();
        int unsigned start;
        int unsigned roll;
        int unsigned n;
        start = items_sent;
        while (items_sent - start < ITEM_TARGET) begin
            roll = $urandom_range(99);
            if (roll < 70)
                n = $urandom_range(12, 1);
            else if (roll < 92)
                n = $urandom_range(40, 13);
            else if (roll < 98)
                n = $urandom_range(DEPTH, 41);
            else
                n = $urandom_range(DEPTH + 8, DEPTH + 1);
            send_set(n, t_key_style'($urandom_range(3)));
            if ($urandom_range(9) == 0)
                wait_sorted_drained();
        end
        wait_sorted_drained();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_single_record();
        test_field_extremes();
        test_equal_keys();
        test_presorted_runs();
        test_full_store();
        test_overflow();
        test_no_idle();
        test_random_sets();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sorted_wr != sorted_rd)
            $error("%0d sorted beats never arrived", sorted_wr - sorted_rd);
        if (err_count == 0 && sorted_wr == sorted_rd)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule
